/* rtl/core/psk_pkg.sv */
`timescale 1ns / 1ps
// Package for the point sorter: sizes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package psk_pkg;

    // Store depth and derived widths
    localparam int POINTS = 64;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = IDX_W + 1;
    localparam int COORD_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;        // store the accepted request
        logic scan_issue;  // read one stored point for the running pass
        logic emit;        // present the selected point as a result
    } t_psk_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;   // this read is the last stored point
        logic emit_last;   // this result is the last one of the run
    } t_psk_sts;

endpackage

/* rtl/core/psk_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the point sorter: load / scan / wait / emit sequencing.
// Depends on psk_pkg.
module psk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_last_point,
    input  psk_pkg::t_psk_sts   i_sts,
    output psk_pkg::t_psk_cmd   o_cmd,
    output logic                busy
);
    import psk_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = start && (r_state == ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_last_point) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_state = i_sts.emit_last ? ST_IDLE : ST_SCAN;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
            end
            ST_WAIT: begin
                o_cmd = '0;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/core/psk_datapath.sv */
`timescale 1ns / 1ps
// Datapath for the point sorter: point store, key register, selection of the
// next point in (key, arrival) order, and the result register. Depends on psk_pkg.
module psk_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psk_pkg::t_psk_cmd             i_cmd,
    output psk_pkg::t_psk_sts             o_sts,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_data,
    input  logic [psk_pkg::COORD_W-1:0]   i_point_x,
    input  logic [psk_pkg::COORD_W-1:0]   i_point_y,
    output logic                          o_result_valid,
    output logic [psk_pkg::COORD_W-1:0]   o_sorted_x,
    output logic [psk_pkg::COORD_W-1:0]   o_sorted_y,
    output logic [psk_pkg::IDX_W-1:0]     o_arrival_index,
    output logic                          o_overflow,
    output logic                          o_last_out
);
    import psk_pkg::*;

    localparam int SK_W = COORD_W + IDX_W;

    // Point store
    logic [COORD_W-1:0] mem_x [POINTS];
    logic [COORD_W-1:0] mem_y [POINTS];

    logic               r_key_is_y;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [IDX_W-1:0]   r_scan;
    logic [IDX_W-1:0]   r_emitted;

    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [COORD_W-1:0] r_rd_x;
    logic [COORD_W-1:0] r_rd_y;

    logic               r_have_best;
    logic [COORD_W-1:0] r_best_x;
    logic [COORD_W-1:0] r_best_y;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_have_prev;
    logic [SK_W-1:0]    r_prev;

    logic               r_out_vld;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_ovf;
    logic               r_out_last;

    logic               room;
    logic [COORD_W-1:0] cand_key;
    logic [SK_W-1:0]    cand;
    logic [SK_W-1:0]    best;
    logic               above_prev;
    logic               below_best;
    logic               take;

    // Sort word: sign-flipped key over arrival index gives a stable order
    assign room     = (r_count < CNT_W'(POINTS));
    assign cand_key = r_key_is_y ? r_rd_y : r_rd_x;
    assign cand     = {~cand_key[COORD_W-1], cand_key[COORD_W-2:0], r_rd_idx};
    assign best     = r_key_is_y
                    ? {~r_best_y[COORD_W-1], r_best_y[COORD_W-2:0], r_best_idx}
                    : {~r_best_x[COORD_W-1], r_best_x[COORD_W-2:0], r_best_idx};
    assign above_prev = !r_have_prev || (cand > r_prev);
    assign below_best = !r_have_best || (cand < best);
    assign take       = r_rd_vld && above_prev && below_best;

    assign o_sts.scan_last = (({1'b0, r_scan} + CNT_W'(1)) == r_count);
    assign o_sts.emit_last = (({1'b0, r_emitted} + CNT_W'(1)) == r_count);

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            mem_x[r_count[IDX_W-1:0]] <= i_point_x;
            mem_y[r_count[IDX_W-1:0]] <= i_point_y;
        end
        r_rd_x   <= mem_x[r_scan];
        r_rd_y   <= mem_y[r_scan];
        r_rd_idx <= r_scan;
    end

    // Control registers: key, fill count, overflow, scan and emit counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_is_y  <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_scan      <= '0;
            r_emitted   <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
            r_have_prev <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.scan_issue;
            r_out_vld <= i_cmd.emit;
            if (i_cfg_valid) begin
                r_key_is_y <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (room) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.scan_issue) begin
                r_scan <= o_sts.scan_last ? '0 : r_scan + IDX_W'(1);
            end
            if (take) begin
                r_have_best <= 1'b1;
            end
            // Retire the selected point; clear the run on the final one
            if (i_cmd.emit) begin
                r_have_best <= 1'b0;
                if (o_sts.emit_last) begin
                    r_have_prev <= 1'b0;
                    r_emitted   <= '0;
                    r_count     <= '0;
                    r_ovf       <= 1'b0;
                end else begin
                    r_have_prev <= 1'b1;
                    r_emitted   <= r_emitted + IDX_W'(1);
                end
            end
        end
    end

    // Payload: running best, previous emitted sort word, result register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_x   <= r_rd_x;
            r_best_y   <= r_rd_y;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.emit) begin
            r_prev     <= best;
            r_out_x    <= r_best_x;
            r_out_y    <= r_best_y;
            r_out_idx  <= r_best_idx;
            r_out_ovf  <= r_ovf;
            r_out_last <= o_sts.emit_last;
        end
    end

    assign o_result_valid  = r_out_vld;
    assign o_sorted_x      = r_out_x;
    assign o_sorted_y      = r_out_y;
    assign o_arrival_index = r_out_idx;
    assign o_overflow      = r_out_ovf;
    assign o_last_out      = r_out_last;

`ifndef ASSERT_OFF
    // A finished pass always has found a point to send
    a_emit_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_have_best)
        else $error("emit without a selected point");

    // Fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(POINTS))
        else $error("fill count beyond store depth");

    // The final result empties the store
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_sts.emit_last) |=> (r_count == '0) && !r_ovf)
        else $error("store not cleared after last result");

    // Results come out in strictly rising sort order within a run
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_have_prev) |-> (best > r_prev))
        else $error("result out of order");
`endif

endmodule

/* rtl/core/point_sort_by_key.sv */
`timescale 1ns / 1ps
// Point sorter top level: loads one point per request, then sends the points
// in rising order of the selected key, ties in load order. Depends on psk_pkg.
// Loading: one request per cycle, busy stays low until the last point.
// Sorting: n stored points give n results; each result needs one full pass
//   over the store through its single read port, followed by a wait state and
//   an emit state. Results cannot be held off by the receiver.
// Reset is synchronous, active low; it empties the store and selects x.
module point_sort_by_key (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [psk_pkg::COORD_W-1:0]   i_point_x,
    input  logic [psk_pkg::COORD_W-1:0]   i_point_y,
    input  logic                          i_last_point,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    output logic                          o_result_valid,
    output logic [psk_pkg::COORD_W-1:0]   o_sorted_x,
    output logic [psk_pkg::COORD_W-1:0]   o_sorted_y,
    output logic [psk_pkg::IDX_W-1:0]     o_arrival_index,
    output logic                          o_overflow,
    output logic                          o_last_out
);
    import psk_pkg::*;

    t_psk_cmd cmd;
    t_psk_sts sts;

    // Key register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    psk_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_last_point (i_last_point),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .busy         (busy)
    );

    psk_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .o_result_valid  (o_result_valid),
        .o_sorted_x      (o_sorted_x),
        .o_sorted_y      (o_sorted_y),
        .o_arrival_index (o_arrival_index),
        .o_overflow      (o_overflow),
        .o_last_out      (o_last_out)
    );

endmodule
